// ===== src/keyed_universal_hash_engine_core_macros.svh =====
// Assertion macros shared by the hash engine RTL.
`ifndef KEYED_UNIVERSAL_HASH_ENGINE_CORE_MACROS_SVH
`define KEYED_UNIVERSAL_HASH_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KUHE_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kuhe: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KUHE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kuhe: next-cycle check failed");
`else
`define KUHE_ASSERT_IMPL(label, pre, post)
`define KUHE_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== src/kuhe_pkg.sv =====
// Types and constants for the keyed universal hash engine.
package kuhe_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // Hash mode codes; the two unused codes fall to the default arms.
    typedef enum logic [2:0] {
        MODE_MULTILINEAR = 3'd0,
        MODE_HALF_MULT   = 3'd1,
        MODE_NH          = 3'd2,
        MODE_SQUARES     = 3'd3,
        MODE_LINEAR      = 3'd4,
        MODE_XAMA        = 3'd5
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_START_KEY = 2'd1
    } reg_idx_t;

    // How lane results combine and fold into the accumulator.
    typedef enum logic [1:0] {
        MRG_ADD  = 2'd0,
        MRG_XOR  = 2'd1,
        MRG_HOLD = 2'd2
    } merge_op_t;

    // Per-item control that travels down the pipeline with the data.
    typedef struct packed {
        merge_op_t op;
        logic      seed_key;  // seed from start_key at the first pair
        logic      full_out;  // emit the whole accumulator
        logic      last;
    } ctrl_t;

endpackage

// ===== src/kuhe_lane.sv =====
// One multiply-add lane: prod = a * b + addend, modulo 2^64, two stages.
module kuhe_lane
    import kuhe_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic [ACC_W-1:0] addend,
    output logic [ACC_W-1:0] prod
);

    logic [ACC_W-1:0]  ll_prod;
    logic [WORD_W-1:0] lh_prod;
    logic [WORD_W-1:0] hl_prod;

    logic [ACC_W-1:0]  ll_reg;
    logic [WORD_W-1:0] cross_reg;
    logic [ACC_W-1:0]  addend_reg;
    logic [ACC_W-1:0]  prod_reg;

    // Only the low halves of the cross products reach bits below 2^64.
    assign ll_prod = ACC_W'(a[WORD_W-1:0]) * ACC_W'(b[WORD_W-1:0]);
    assign lh_prod = a[WORD_W-1:0] * b[ACC_W-1:WORD_W];
    assign hl_prod = a[ACC_W-1:WORD_W] * b[WORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg     <= ll_prod;
            cross_reg  <= lh_prod + hl_prod;
            addend_reg <= addend;
            prod_reg   <= ll_reg + {cross_reg, {WORD_W{1'b0}}} + addend_reg;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/kuhe_merge.sv =====
// Merge stage: combine the two lane results into one registered delta.
module kuhe_merge
    import kuhe_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  merge_op_t        op,
    input  logic [ACC_W-1:0] lane0,
    input  logic [ACC_W-1:0] lane1,
    output logic [ACC_W-1:0] delta
);

    logic [ACC_W-1:0] delta_next;
    logic [ACC_W-1:0] delta_reg;

    always_comb
    begin
        unique case (op)
            MRG_XOR: delta_next = lane0 ^ lane1;
            MRG_ADD: delta_next = lane0 + lane1;
            default: delta_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta_reg <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

// ===== src/keyed_universal_hash_engine_core.sv =====
// Top level of the keyed universal hash engine: two lanes, merge, accumulator.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  in      | in_valid / in_ready       | msg_even, msg_odd, key_a..key_d, last
//  out     | out_valid / out_ready     | hash_value
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One word pair is taken every cycle unless a waiting result stalls the pipe;
// the accumulator update is the only loop, so throughput is one pair per clock.
// hash_value is registered through the operand, partial product, lane sum,
// merge and accumulate/output stages after the last pair's transfer.
// rst_n clears the accumulator, the stage valid bits and the output slot.
// A result waiting in the output register stalls the whole pipeline.
`include "keyed_universal_hash_engine_core_macros.svh"

module keyed_universal_hash_engine_core
    import kuhe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    msg_even,
    input  logic [WORD_W-1:0]    msg_odd,
    input  logic [ACC_W-1:0]     key_a,
    input  logic [ACC_W-1:0]     key_b,
    input  logic [ACC_W-1:0]     key_c,
    input  logic [ACC_W-1:0]     key_d,
    input  logic                 last,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ACC_W-1:0]     hash_value,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ACC_W-1:0]     cfg_data
);

    localparam int unsigned STAGES = 4;

    // Configuration registers
    logic [2:0]       mode_reg;
    logic [ACC_W-1:0] start_key_reg;

    // Pipeline advance: everything moves when the output slot can take a result
    logic adv;

    // Operand formation (stage 0 inputs)
    logic [ACC_W-1:0]  sum_a;
    logic [ACC_W-1:0]  sum_b;
    logic [WORD_W-1:0] nh_t;
    logic [WORD_W-1:0] nh_u;
    logic [ACC_W-1:0]  l0_a_next, l0_b_next, l0_c_next;
    logic [ACC_W-1:0]  l1_a_next, l1_b_next, l1_c_next;
    ctrl_t             ctrl_next;

    logic [ACC_W-1:0]  l0_a_reg, l0_b_reg, l0_c_reg;
    logic [ACC_W-1:0]  l1_a_reg, l1_b_reg, l1_c_reg;

    ctrl_t             ctrl_reg [STAGES];
    logic [STAGES-1:0] vld_reg;

    logic [ACC_W-1:0]  lane0_prod;
    logic [ACC_W-1:0]  lane1_prod;
    logic [ACC_W-1:0]  delta;

    // Accumulator
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  acc_base;
    logic              at_start_reg;
    logic [ACC_W-1:0]  hash_next;

    // Output slot
    logic              out_valid_reg;
    logic [ACC_W-1:0]  hash_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes drop silently
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MULTILINEAR;
            start_key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[2:0];
                REG_START_KEY: start_key_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Map the item onto two multiply-add lanes for the current mode
    // ---------------------------------------------------------------
    assign sum_a = key_a + ACC_W'(msg_even);
    assign sum_b = key_b + ACC_W'(msg_odd);
    assign nh_t  = key_a[WORD_W-1:0] + msg_even;
    assign nh_u  = key_a[ACC_W-1:WORD_W] + msg_odd;

    always_comb
    begin
        l0_a_next = '0;
        l0_b_next = '0;
        l0_c_next = '0;
        l1_a_next = '0;
        l1_b_next = '0;
        l1_c_next = '0;
        ctrl_next = '{op: MRG_HOLD, seed_key: 1'b0, full_out: 1'b0, last: last};
        unique case (mode_reg)
            MODE_MULTILINEAR:
            begin
                l0_a_next          = key_a;
                l0_b_next          = ACC_W'(msg_even);
                l1_a_next          = key_b;
                l1_b_next          = ACC_W'(msg_odd);
                ctrl_next.op       = MRG_ADD;
                ctrl_next.seed_key = 1'b1;
            end
            MODE_HALF_MULT:
            begin
                l0_a_next          = sum_a;
                l0_b_next          = sum_b;
                ctrl_next.op       = MRG_ADD;
                ctrl_next.seed_key = 1'b1;
            end
            MODE_NH:
            begin
                l0_a_next          = ACC_W'(nh_t);
                l0_b_next          = ACC_W'(nh_u);
                ctrl_next.op       = MRG_ADD;
                ctrl_next.full_out = 1'b1;
            end
            MODE_SQUARES:
            begin
                l0_a_next          = sum_a;
                l0_b_next          = sum_a;
                l1_a_next          = sum_b;
                l1_b_next          = sum_b;
                ctrl_next.op       = MRG_ADD;
                ctrl_next.seed_key = 1'b1;
            end
            MODE_LINEAR:
            begin
                l0_a_next    = key_a;
                l0_b_next    = ACC_W'(msg_even);
                l0_c_next    = key_b;
                l1_a_next    = key_c;
                l1_b_next    = ACC_W'(msg_odd);
                l1_c_next    = key_d;
                ctrl_next.op = MRG_XOR;
            end
            MODE_XAMA:
            begin
                l0_a_next    = sum_a;
                l0_b_next    = sum_b;
                l0_c_next    = key_c;
                ctrl_next.op = MRG_XOR;
            end
            default:
            begin
                // Unused codes: seed from zero and hold the accumulator
                ctrl_next.op = MRG_HOLD;
            end
        endcase
    end

    // Operand registers: payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l0_a_reg    <= l0_a_next;
            l0_b_reg    <= l0_b_next;
            l0_c_reg    <= l0_c_next;
            l1_a_reg    <= l1_a_next;
            l1_b_reg    <= l1_b_next;
            l1_c_reg    <= l1_c_next;
            ctrl_reg[0] <= ctrl_next;
            for (int i = 1; i < STAGES; i++)
            begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    // Stage valid bits: advance with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // ---------------------------------------------------------------
    // Lanes and merge
    // ---------------------------------------------------------------
    kuhe_lane u_lane0
    (
        .clk    (clk),
        .en     (adv),
        .a      (l0_a_reg),
        .b      (l0_b_reg),
        .addend (l0_c_reg),
        .prod   (lane0_prod)
    );

    kuhe_lane u_lane1
    (
        .clk    (clk),
        .en     (adv),
        .a      (l1_a_reg),
        .b      (l1_b_reg),
        .addend (l1_c_reg),
        .prod   (lane1_prod)
    );

    kuhe_merge u_merge
    (
        .clk   (clk),
        .en    (adv),
        .op    (ctrl_reg[STAGES-2].op),
        .lane0 (lane0_prod),
        .lane1 (lane1_prod),
        .delta (delta)
    );

    // ---------------------------------------------------------------
    // Accumulate: seed on the first pair, fold the delta in
    // ---------------------------------------------------------------
    always_comb
    begin
        if (at_start_reg)
        begin
            acc_base = ctrl_reg[STAGES-1].seed_key ? start_key_reg : '0;
        end
        else
        begin
            acc_base = acc_reg;
        end

        unique case (ctrl_reg[STAGES-1].op)
            MRG_ADD: acc_next = acc_base + delta;
            MRG_XOR: acc_next = acc_base ^ delta;
            default: acc_next = acc_base;
        endcase

        // NH emits the full sum; others the sign-extended upper half
        if (ctrl_reg[STAGES-1].full_out)
        begin
            hash_next = acc_next;
        end
        else
        begin
            hash_next = {{WORD_W{acc_next[ACC_W-1]}}, acc_next[ACC_W-1:WORD_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[STAGES-1] && ctrl_reg[STAGES-1].last;
            if (vld_reg[STAGES-1])
            begin
                acc_reg      <= acc_next;
                at_start_reg <= ctrl_reg[STAGES-1].last;
            end
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hash_reg <= hash_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A pending result always belongs to a finished string.
    `KUHE_ASSERT_IMPL(a_out_at_start, out_valid_reg, at_start_reg)
    // A non-last pair leaving the merge stage never raises a result.
    `KUHE_ASSERT_NEXT(a_no_result_mid, adv && vld_reg[STAGES-1] && !ctrl_reg[STAGES-1].last, !out_valid_reg)
    // A new result comes only from a valid last pair.
    `KUHE_ASSERT_IMPL(a_result_src, $rose(out_valid_reg), $past(vld_reg[STAGES-1] && ctrl_reg[STAGES-1].last))

endmodule

// ===== dv/keyed_universal_hash_engine_core_tb.sv =====
// Self-checking testbench for the keyed universal hash engine core.
`timescale 1ns / 100ps

module testbench;
    import kuhe_pkg::*;

    // Spare mode codes: seed from zero, hold the accumulator, emit the upper half.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    // Register indexes past the end of the map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    // Settle margin so pairs still in the pipe have landed in the accumulator.
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 24;
    localparam int PHASE_PAIRS   = 80;
    localparam int CYCLE_LIMIT   = 500000;

    // One word pair as it crosses the input channel.
    typedef struct packed {
        logic [WORD_W-1:0] msg_even;
        logic [WORD_W-1:0] msg_odd;
        logic [ACC_W-1:0]  key_a;
        logic [ACC_W-1:0]  key_b;
        logic [ACC_W-1:0]  key_c;
        logic [ACC_W-1:0]  key_d;
        logic              last;
    } word_pair_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [WORD_W-1:0]    msg_even;
    logic [WORD_W-1:0]    msg_odd;
    logic [ACC_W-1:0]     key_a;
    logic [ACC_W-1:0]     key_b;
    logic [ACC_W-1:0]     key_c;
    logic [ACC_W-1:0]     key_d;
    logic                 last;
    logic                 out_valid;
    logic                 out_ready;
    logic [ACC_W-1:0]     hash_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ACC_W-1:0]     cfg_data;

    keyed_universal_hash_engine_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .msg_even   (msg_even),
        .msg_odd    (msg_odd),
        .key_a      (key_a),
        .key_b      (key_b),
        .key_c      (key_c),
        .key_d      (key_d),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Hash predictor: shadow registers, running accumulator, string flag.
    // ------------------------------------------------------------------
    logic [2:0]       hash_mode;
    logic [ACC_W-1:0] hash_start_key;
    logic [ACC_W-1:0] running_sum;
    logic             string_fresh;
    logic [ACC_W-1:0] expected_hashes[$];

    int error_count;
    int cycle_count;
    int string_pairs_left;
    // Sender burst state and knobs that the tests flip per phase.
    int burst_left;
    bit sender_gaps;
    bit receiver_stalls;
    bit hold_request;
    logic [ACC_W-1:0] wanted_hash;

    // Fold one pair into the running sum under the given mode (all mod 2^64).
    function automatic logic [ACC_W-1:0] fold_pair(input logic [2:0] m,
                                                   input logic [ACC_W-1:0] sum,
                                                   input word_pair_t p);
        logic [ACC_W-1:0] m0;
        logic [ACC_W-1:0] m1;
        logic [ACC_W-1:0] x;
        logic [ACC_W-1:0] y;
        logic [ACC_W-1:0] acc;
        logic [WORD_W-1:0] lo_lane;
        logic [WORD_W-1:0] hi_lane;
        m0  = {32'd0, p.msg_even};
        m1  = {32'd0, p.msg_odd};
        acc = sum;
        case (m)
            MODE_MULTILINEAR: acc = acc + p.key_a * m0 + p.key_b * m1;
            MODE_HALF_MULT:   acc = acc + (p.key_a + m0) * (p.key_b + m1);
            MODE_NH:
            begin
                // Both lanes wrap at 32 bits before the full-width product.
                lo_lane = p.key_a[WORD_W-1:0] + p.msg_even;
                hi_lane = p.key_a[ACC_W-1:WORD_W] + p.msg_odd;
                x = {32'd0, lo_lane};
                y = {32'd0, hi_lane};
                acc = acc + x * y;
            end
            MODE_SQUARES:
            begin
                x = p.key_a + m0;
                y = p.key_b + m1;
                acc = acc + x * x + y * y;
            end
            MODE_LINEAR:
            begin
                acc = acc ^ (p.key_a * m0 + p.key_b);
                acc = acc ^ (p.key_c * m1 + p.key_d);
            end
            MODE_XAMA:        acc = acc ^ ((p.key_a + m0) * (p.key_b + m1) + p.key_c);
            default:          acc = sum;
        endcase
        return acc;
    endfunction

    // NH hands out the whole sum; every other code the sign-extended top half.
    function automatic logic [ACC_W-1:0] format_hash(input logic [2:0] m,
                                                     input logic [ACC_W-1:0] sum);
        if (m == MODE_NH)
            return sum;
        return {{32{sum[ACC_W-1]}}, sum[ACC_W-1:WORD_W]};
    endfunction

    // Advance the predictor by one accepted pair; queue a hash on the last one.
    task automatic absorb_pair(input word_pair_t p);
        logic [ACC_W-1:0] seed;
        seed = '0;
        if (hash_mode == MODE_MULTILINEAR || hash_mode == MODE_HALF_MULT
            || hash_mode == MODE_SQUARES)
            seed = hash_start_key;
        running_sum = fold_pair(hash_mode, string_fresh ? seed : running_sum, p);
        if (p.last)
            expected_hashes.push_back(format_hash(hash_mode, running_sum));
        string_fresh = p.last;
    endtask

    // ------------------------------------------------------------------
    // Random field values, biased toward the all-zero and all-one corners.
    // ------------------------------------------------------------------
    function automatic logic [ACC_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_pair_t pick_pair(input logic is_last);
        word_pair_t p;
        p.msg_even = pick_word();
        p.msg_odd  = pick_word();
        p.key_a    = pick_key();
        p.key_b    = pick_key();
        p.key_c    = pick_key();
        p.key_d    = pick_key();
        p.last     = is_last;
        return p;
    endfunction

    // Mostly short strings, now and then a long one.
    function automatic int pick_string_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 32);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers: drive on the falling edge, sample on the rising edge.
    // ------------------------------------------------------------------

    // Offer one pair and hold it until the transfer; idle between bursts.
    task automatic send_pair(input word_pair_t p);
        int gap;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        msg_even <= p.msg_even;
        msg_odd  <= p.msg_odd;
        key_a    <= p.key_a;
        key_b    <= p.key_b;
        key_c    <= p.key_c;
        key_d    <= p.key_d;
        last     <= p.last;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_pair(p);
    endtask

    // Drop valid, wait out every pending hash, then let the pipe settle so
    // non-last pairs still in flight have landed in the accumulator.
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; callers make sure the engine is idle first.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ACC_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MODE)
            hash_mode = data[2:0];
        else if (idx == REG_START_KEY)
            hash_start_key = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each hash transfer with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $error("hash_value: no result expected, actual %h", hash_value);
                error_count++;
            end
            else
            begin
                wanted_hash = expected_hashes.pop_front();
                if (hash_value !== wanted_hash)
                begin
                    $error("hash_value: expected %h, actual %h", wanted_hash, hash_value);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready runs, always-ready stretches, one long hold-off.
    // ------------------------------------------------------------------
    initial
    begin
        int run;
        logic level;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                // Hold ready low for a long stretch so the pipe backs up.
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!receiver_stalls)
            begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                run   = $urandom_range(1, 12);
                level = ($urandom_range(0, 9) < 6);
                repeat (run)
                begin
                    @(negedge clk);
                    out_ready <= level;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hash under reset defaults, then drive the field extremes.
    task automatic test_reset_defaults_and_extremes();
        word_pair_t p;
        p = '1;
        send_pair(p);
        wait_for_idle();
        write_register(REG_START_KEY, '1);
        write_register(REG_MODE, {61'd0, MODE_MULTILINEAR});
        p = '0;
        p.last = 1'b1;
        send_pair(p);
        p = '0;
        p.msg_even = '1;
        p.key_a    = '1;
        send_pair(p);
        p = '0;
        p.msg_odd = '1;
        p.key_b   = '1;
        p.key_c   = '1;
        p.key_d   = '1;
        p.last    = 1'b1;
        send_pair(p);
    endtask

    // Run one two-pair string under the given mode code.
    task automatic hash_two_pairs_in_mode(input logic [2:0] code);
        wait_for_idle();
        write_register(REG_MODE, {61'd0, code});
        write_register(REG_START_KEY, pick_key());
        send_pair(pick_pair(1'b0));
        send_pair(pick_pair(1'b1));
    endtask

    task automatic test_every_mode();
        hash_two_pairs_in_mode(MODE_MULTILINEAR);
        hash_two_pairs_in_mode(MODE_HALF_MULT);
        hash_two_pairs_in_mode(MODE_NH);
        hash_two_pairs_in_mode(MODE_SQUARES);
        hash_two_pairs_in_mode(MODE_LINEAR);
        hash_two_pairs_in_mode(MODE_XAMA);
        hash_two_pairs_in_mode(MODE_SPARE_6);
        hash_two_pairs_in_mode(MODE_SPARE_7);
    endtask

    // Change registers inside a string: the seed stays with the first pair,
    // each pair folds under the current mode, the format follows the last pair.
    // Then write the unmapped indexes and confirm nothing moved.
    task automatic test_midstring_register_change();
        wait_for_idle();
        write_register(REG_MODE, {61'd0, MODE_HALF_MULT});
        write_register(REG_START_KEY, {$urandom, $urandom});
        send_pair(pick_pair(1'b0));
        wait_for_idle();
        write_register(REG_START_KEY, {$urandom, $urandom});
        write_register(REG_MODE, {61'd0, MODE_MULTILINEAR});
        send_pair(pick_pair(1'b0));
        wait_for_idle();
        write_register(REG_MODE, {61'd0, MODE_NH});
        send_pair(pick_pair(1'b1));
        wait_for_idle();
        write_register(REG_MODE, {61'd0, MODE_SQUARES});
        write_register(REG_SPARE_2, {$urandom, $urandom});
        write_register(REG_SPARE_3, {$urandom, $urandom});
        send_pair(pick_pair(1'b1));
    endtask

    // Block the output for a long stretch while pairs keep coming.
    task automatic test_output_backpressure();
        wait_for_idle();
        write_register(REG_MODE, {61'd0, MODE_XAMA});
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (48)
            send_pair(pick_pair(1'b1));
    endtask

    // Random strings across many register settings; strings run across phase
    // boundaries, so some register changes also land mid-string.
    task automatic test_random_strings();
        logic [2:0] code;
        logic [ACC_W-1:0] seed_word;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_for_idle();
            if ($urandom_range(0, 9) < 8)
                code = 3'($urandom_range(0, 5));
            else
                code = 3'($urandom_range(6, 7));
            case (phase)
                0:       seed_word = '0;
                1:       seed_word = '1;
                default: seed_word = pick_key();
            endcase
            // Upper bits of a mode write are don't-care; fill them with noise.
            write_register(REG_MODE, {$urandom, 29'($urandom_range(0, 536870911)), code});
            write_register(REG_START_KEY, seed_word);
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               {$urandom, $urandom});
            sender_gaps     = ($urandom_range(0, 2) != 0);
            receiver_stalls = ($urandom_range(0, 2) != 0);
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                if (string_pairs_left == 0)
                    string_pairs_left = pick_string_length();
                send_pair(pick_pair(string_pairs_left == 1));
                string_pairs_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog and test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        msg_even  = '0;
        msg_odd   = '0;
        key_a     = '0;
        key_b     = '0;
        key_c     = '0;
        key_d     = '0;
        last      = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;

        hash_mode         = MODE_MULTILINEAR;
        hash_start_key    = '0;
        running_sum       = '0;
        string_fresh      = 1'b1;
        error_count       = 0;
        string_pairs_left = 0;
        burst_left        = 0;
        sender_gaps       = 1'b1;
        receiver_stalls   = 1'b1;
        hold_request      = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults_and_extremes();
        test_every_mode();
        test_midstring_register_change();
        test_output_backpressure();
        test_random_strings();
        wait_for_idle();

        if (expected_hashes.size() != 0)
        begin
            $error("hash_value: %0d results never arrived", expected_hashes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== keyed_universal_hash_engine_core.f =====
+incdir+src
src/kuhe_pkg.sv
src/kuhe_lane.sv
src/kuhe_merge.sv
src/keyed_universal_hash_engine_core.sv
dv/keyed_universal_hash_engine_core_tb.sv
